@@ rtl/kst_pkg.sv @@
// kst_pkg: shared constants, types and character helpers for the keyed square cipher
// no dependencies; imported by kst_core, keyed_square_transpose_cipher and the testbench
package kst_pkg;

	localparam int SqSide = 5;
	localparam int SqSize = SqSide * SqSide;
	localparam int PosW   = $clog2(SqSize);
	localparam int CharW  = 8;
	localparam int KindW  = 3;
	localparam int MapDepth = 1 << CharW;

	// item kinds
	localparam logic [KindW-1:0] KIND_CLEAR  = 3'd0;
	localparam logic [KindW-1:0] KIND_KEY    = 3'd1;
	localparam logic [KindW-1:0] KIND_FINISH = 3'd2;
	localparam logic [KindW-1:0] KIND_ENC    = 3'd3;
	localparam logic [KindW-1:0] KIND_DEC    = 3'd4;

	localparam logic [CharW-1:0] CHAR_UP_A  = 8'h41;
	localparam logic [CharW-1:0] CHAR_UP_Z  = 8'h5a;
	localparam logic [CharW-1:0] CHAR_LOW_A = 8'h61;
	localparam logic [CharW-1:0] CHAR_LOW_Z = 8'h7a;
	localparam logic [CharW-1:0] CASE_DIFF  = 8'h20;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [CharW-1:0] ch;
	} kst_req_t;

	typedef struct packed {
		logic [CharW-1:0] out_char;
		logic             found;
	} kst_res_t;

	function automatic logic [CharW-1:0] kst_to_up(input logic [CharW-1:0] c);
		kst_to_up = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_DIFF : c;
	endfunction

	function automatic logic [CharW-1:0] kst_to_low(input logic [CharW-1:0] c);
		kst_to_low = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CASE_DIFF : c;
	endfunction

	// (row, col) -> (col, row) as a small constant table over the square
	function automatic logic [PosW-1:0] kst_transpose(input logic [PosW-1:0] pos);
		logic [PosW-1:0] t;
		t = '0;
		for (int r = 0; r < SqSide; r++) begin
			for (int c = 0; c < SqSide; c++) begin
				if (pos == PosW'(r * SqSide + c)) begin
					t = PosW'(c * SqSide + r);
				end
			end
		end
		kst_transpose = t;
	endfunction

endpackage

@@ rtl/kst_ram.sv @@
// kst_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/kst_core.sv @@
// kst_core: sequencer around the square ram and the character-to-position map ram
// depends on kst_pkg and kst_ram
module kst_core
	import kst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  kst_req_t req,
	output logic     ready,
	output logic     res_valid,
	output kst_res_t res,
	input  logic     out_ready
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RDPOS = 3'd1;
	localparam logic [2:0] S_RDSQ  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_RDT   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]       state_q;
	logic [PosW-1:0]  fill_q;
	logic [KindW-1:0] kind_q;
	logic [CharW-1:0] char_q;
	logic [CharW-1:0] probe_q;
	logic [PosW-1:0]  pos_q;
	logic [PosW-1:0]  trans_q;
	kst_res_t         res_q;

	logic [CharW-1:0] sq_rdata;
	logic [PosW-1:0]  pos_rdata;
	logic [PosW-1:0]  sq_raddr;
	logic [PosW-1:0]  trans_d;
	logic [PosW-1:0]  fill_after;
	logic [CharW-1:0] rdt_char;
	logic             hit;
	logic             miss;
	logic             is_lookup;
	logic             append_en;
	logic             more_letters;

	// square: position -> character
	kst_ram #(.WIDTH(CharW), .DEPTH(SqSize)) u_sq_ram (
		.clk   (clk),
		.we    (append_en),
		.waddr (fill_q),
		.wdata (probe_q),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	// map: character -> position, checked against the square before use
	kst_ram #(.WIDTH(PosW), .DEPTH(MapDepth)) u_pos_ram (
		.clk   (clk),
		.we    (append_en),
		.waddr (probe_q),
		.wdata (fill_q),
		.raddr (probe_q),
		.rdata (pos_rdata)
	);

	always_comb begin
		hit = (pos_q < fill_q) && (sq_rdata == probe_q);
		if (hit) begin
			miss = 1'b0;
		end else begin
			miss = 1'b1;
		end
		is_lookup  = (kind_q == KIND_ENC) || (kind_q == KIND_DEC);
		append_en  = (state_q == S_CHECK) && !is_lookup && miss && (fill_q < PosW'(SqSize));
		fill_after = append_en ? fill_q + 1'b1 : fill_q;
		more_letters = (kind_q == KIND_FINISH) && (probe_q != CHAR_UP_Z)
			&& (fill_after < PosW'(SqSize));
		trans_d  = kst_transpose(pos_q);
		sq_raddr = (state_q == S_CHECK) ? trans_d : pos_rdata;
		rdt_char = (trans_q < fill_q) ? sq_rdata : '0;
		if (kind_q == KIND_DEC) begin
			rdt_char = kst_to_low(rdt_char);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req.kind)
							KIND_CLEAR: fill_q <= '0;
							KIND_KEY, KIND_ENC, KIND_DEC: state_q <= S_RDPOS;
							KIND_FINISH: begin
								if (fill_q < PosW'(SqSize)) begin
									state_q <= S_RDPOS;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RDPOS: state_q <= S_RDSQ;
				S_RDSQ:  state_q <= S_CHECK;
				S_CHECK: begin
					fill_q <= fill_after;
					if (is_lookup) begin
						if (miss) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RDT;
						end
					end else if (more_letters) begin
						state_q <= S_RDPOS;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RDT: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q <= req.kind;
					char_q <= req.ch;
					case (req.kind)
						KIND_FINISH: probe_q <= CHAR_UP_A;
						KIND_DEC:    probe_q <= req.ch;
						default:     probe_q <= kst_to_up(req.ch);
					endcase
				end
			end
			S_RDSQ: pos_q <= pos_rdata;
			S_CHECK: begin
				trans_q <= trans_d;
				res_q   <= '{out_char: char_q, found: 1'b0};
				if (!is_lookup && more_letters) begin
					probe_q <= probe_q + 1'b1;
				end
			end
			S_RDT: res_q <= '{out_char: rdt_char, found: 1'b1};
			default: res_q <= res_q;
		endcase
	end

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PosW'(SqSize))
		else $error("fill count beyond square size");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && ready && req.kind == KIND_CLEAR) |=> (fill_q == '0))
		else $error("clear did not empty the square");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		append_en |-> (state_q == S_CHECK && fill_q < PosW'(SqSize) && !is_lookup))
		else $error("square written outside an append");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CHECK && !(start && ready)) |=> $stable(fill_q))
		else $error("fill count moved without an item");

endmodule

@@ rtl/keyed_square_transpose_cipher.sv @@
// keyed_square_transpose_cipher: top level, stream ports and result register
// depends on kst_pkg and kst_core (which holds the two kst_ram instances)
//
// Keyed 5x5 square substitution. Send key characters (kind 1) to build the
// square in order, upper-cased and without repeats; extra key characters past 25
// are dropped. A finish item (kind 2) tops the square up with the missing
// letters from A. Encrypt (kind 3) and decrypt (kind 4) each return exactly one
// result transfer: the entry at the transposed (column, row) position, lower-cased
// on decrypt, with found=1, or the input character unchanged with found=0 when it
// is not in the square. Clear (kind 0) empties the square at once; clear, key,
// finish and unused kinds return nothing. The square lives in a 25-entry ram and
// a 256-entry character-to-position ram; a map entry is trusted only after the
// square ram confirms it, so neither ram needs a clearing pass after reset. One
// item is worked at a time: a key character takes a map read, a square read and a
// check/write; encrypt or decrypt takes the same reads and check and, when the
// character is found, one more square read for the transposed entry, then the
// hand-off to the result register, and goes straight to the hand-off when it is
// not. Finish repeats the map read, square read and check for each letter tried,
// and does nothing on a full square. The hand-off cycle stretches while the
// result register still holds an earlier result that downstream has not taken.
// The result register lets a new item start while a result still waits downstream.
module keyed_square_transpose_cipher
	import kst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_char
	input  logic [2:0]  s_tuser,   // [2:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_char
	output logic [0:0]  m_tuser    // [0] found
);

	kst_req_t req;
	kst_res_t res;
	logic     core_ready;
	logic     core_res_valid;
	logic     out_free;

	logic     m_tvalid_q;
	kst_res_t out_q;

	assign req = '{kind: s_tuser, ch: s_tdata};

	// the core only starts on an accepted transfer
	assign s_tready = core_ready;

	// result register is free when empty or drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	kst_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid),
		.req       (req),
		.ready     (core_ready),
		.res_valid (core_res_valid),
		.res       (res),
		.out_ready (out_free)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= core_res_valid;
		end
	end

	// output payload, loaded together with the valid flag
	always_ff @(posedge clk) begin
		if (out_free && core_res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q.out_char;
	assign m_tuser  = out_q.found;

endmodule

@@ verif/tb_keyed_square_transpose_cipher.sv @@
// tb_keyed_square_transpose_cipher: self-checking testbench for the keyed 5x5 square cipher
// depends on kst_pkg and the keyed_square_transpose_cipher rtl; runs stand-alone
// a directed table, then random key/finish/text runs against a local square predictor
`timescale 1ns / 100ps

module tb_keyed_square_transpose_cipher;
	import kst_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 1900;
	localparam int DRAIN_WAIT  = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int PLAN_ROWS   = 24;

	// kind codes the block leaves unused
	localparam logic [KindW-1:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [KindW-1:0] KIND_SPARE_MID = 3'd6;
	localparam logic [KindW-1:0] KIND_SPARE_HI  = 3'd7;

	// one row of the directed table; want_* only counts when typed is set
	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [CharW-1:0] ch;
		logic             typed;
		logic [CharW-1:0] want_char;
		logic             want_found;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] in_char
	logic [2:0]  s_tuser;    // [2:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // [7:0] out_char
	logic [0:0]  m_tuser;    // [0] found

	// predictor copy of the key square
	logic [CharW-1:0] square_cells [SqSize];
	int unsigned      square_fill;

	kst_res_t  expected_subs [$];
	kst_res_t  oldest_sub;
	plan_row_t plan [PLAN_ROWS];

	int  error_count;
	int  cycle_count;
	int  sent_items;
	bit  gaps_off;
	bit  stall_request;

	keyed_square_transpose_cipher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic logic [CharW-1:0] upper_of(input logic [CharW-1:0] c);
		return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - 8'h20 : c;
	endfunction

	function automatic logic [CharW-1:0] lower_of(input logic [CharW-1:0] c);
		return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + 8'h20 : c;
	endfunction

	function automatic void wipe_square();
		foreach (square_cells[i]) square_cells[i] = '0;
		square_fill = 0;
	endfunction

	// index of the first filled cell holding c, SqSize when absent
	function automatic int unsigned cell_of(input logic [CharW-1:0] c);
		for (int unsigned i = 0; i < square_fill; i++) begin
			if (square_cells[i] == c) begin
				return i;
			end
		end
		return SqSize;
	endfunction

	// append only while room is left and the char is new
	function automatic void add_cell(input logic [CharW-1:0] c);
		if (square_fill < SqSize && cell_of(c) == SqSize) begin
			square_cells[square_fill] = c;
			square_fill++;
		end
	endfunction

	// advances the square for one accepted item; returns 1 when a result is due
	function automatic bit substitute(input logic [KindW-1:0] kind, input logic [CharW-1:0] ch,
			output kst_res_t sub);
		int unsigned      pos;
		logic [CharW-1:0] probe;
		logic [CharW-1:0] swapped;
		sub = '0;
		substitute = 1'b0;
		case (kind)
			KIND_CLEAR: begin
				wipe_square();
			end
			KIND_KEY: begin
				add_cell(upper_of(ch));
			end
			KIND_FINISH: begin
				// top up with missing letters from A while room is left
				for (int c = CHAR_UP_A; c <= CHAR_UP_Z && square_fill < SqSize; c++) begin
					add_cell(CharW'(c));
				end
			end
			KIND_ENC, KIND_DEC: begin
				// encrypt matches upper case, decrypt the raw char
				probe = (kind == KIND_ENC) ? upper_of(ch) : ch;
				pos = cell_of(probe);
				if (pos >= SqSize) begin
					sub.out_char = ch;
					sub.found = 1'b0;
				end else begin
					// (row, col) -> (col, row); an unfilled cell reads as zero
					swapped = square_cells[(pos % SqSide) * SqSide + pos / SqSide];
					sub.out_char = (kind == KIND_DEC) ? lower_of(swapped) : swapped;
					sub.found = 1'b1;
				end
				substitute = 1'b1;
			end
			default: begin
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic bit sender_idles();
		return !gaps_off && $urandom_range(0, 99) < 31;
	endfunction

	// mix of upper, lower, any byte and chars already in the square
	function automatic logic [CharW-1:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) return CHAR_UP_A + CharW'($urandom_range(0, 25));
		if (r < 65) return CHAR_LOW_A + CharW'($urandom_range(0, 25));
		if (r < 82) return CharW'($urandom_range(0, 255));
		return square_cells[$urandom_range(0, SqSize - 1)];
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic offer(input logic [KindW-1:0] kind, input logic [CharW-1:0] ch,
			output bit due, output kst_res_t sub);
		while (sender_idles()) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		due = substitute(kind, ch, sub);
		if (kind <= KIND_DEC) sent_items++;
		@(negedge clk);
	endtask

	task automatic send_checked(input logic [KindW-1:0] kind, input logic [CharW-1:0] ch);
		bit       due;
		kst_res_t sub;
		offer(kind, ch, due, sub);
		if (due) expected_subs.push_back(sub);
	endtask

	// ---------------------------------------------------------------- result check

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_subs.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, got char %h found %b",
					$time, m_tdata, m_tuser[0]);
			end else begin
				oldest_sub = expected_subs.pop_front();
				if (m_tdata !== oldest_sub.out_char) begin
					error_count++;
					$display("%0t: out_char mismatch, expected %h, got %h",
						$time, oldest_sub.out_char, m_tdata);
				end
				if (m_tuser[0] !== oldest_sub.found) begin
					error_count++;
					$display("%0t: found mismatch, expected %b, got %b",
						$time, oldest_sub.found, m_tuser[0]);
				end
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[keyed_square_transpose_cipher] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- receiver

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				// long hold-off so the block fills up and blocks its input
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				stall_request = 1'b0;
			end
			m_tready = gaps_off ? 1'b1 : ($urandom_range(0, 99) >= 31);
		end
	end

	// ---------------------------------------------------------------- sender and end of run

	initial begin
		bit       due;
		bit       held;
		bit       drained;
		kst_res_t sub;
		int       key_len;
		int       text_len;

		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_CLEAR;
		arst_n = 1'b0;
		error_count = 0;
		cycle_count = 0;
		sent_items = 0;
		gaps_off = 1'b0;
		stall_request = 1'b0;
		held = 1'b0;
		drained = 1'b0;
		wipe_square();

		plan = '{
			// empty square: everything passes through, zero never matches
			{KIND_ENC,      8'h41, 1'b1, 8'h41, 1'b0},
			{KIND_DEC,      8'h00, 1'b1, 8'h00, 1'b0},
			{KIND_ENC,      8'hff, 1'b1, 8'hff, 1'b0},
			// lower-case key char, then its upper-case repeat is dropped
			{KIND_KEY,      8'h6b, 1'b0, 8'h00, 1'b0},
			{KIND_KEY,      8'h4b, 1'b0, 8'h00, 1'b0},
			// first cell transposes onto itself
			{KIND_ENC,      8'h6b, 1'b1, 8'h4b, 1'b1},
			// non-letter key chars are kept as they are, zero included
			{KIND_KEY,      8'hff, 1'b0, 8'h00, 1'b0},
			{KIND_KEY,      8'h00, 1'b0, 8'h00, 1'b0},
			// partial square: transposed cell not filled yet
			{KIND_DEC,      8'hff, 1'b0, 8'h00, 1'b0},
			{KIND_DEC,      8'h00, 1'b0, 8'h00, 1'b0},
			{KIND_ENC,      8'h7a, 1'b1, 8'h7a, 1'b0},
			// fill, then a second finish on a full square
			{KIND_FINISH,   8'h00, 1'b0, 8'h00, 1'b0},
			{KIND_FINISH,   8'hff, 1'b0, 8'h00, 1'b0},
			// key char on a full square is ignored
			{KIND_KEY,      8'h51, 1'b0, 8'h00, 1'b0},
			{KIND_ENC,      8'h71, 1'b0, 8'h00, 1'b0},
			// decrypt matches raw, so lower case misses
			{KIND_DEC,      8'h61, 1'b1, 8'h61, 1'b0},
			{KIND_DEC,      8'h41, 1'b0, 8'h00, 1'b0},
			{KIND_ENC,      8'h80, 1'b1, 8'h80, 1'b0},
			// unused kinds give nothing
			{KIND_SPARE_LO, 8'h41, 1'b0, 8'h00, 1'b0},
			{KIND_SPARE_MID,8'h00, 1'b0, 8'h00, 1'b0},
			{KIND_SPARE_HI, 8'hff, 1'b0, 8'h00, 1'b0},
			// clear empties the square at once
			{KIND_CLEAR,    8'hff, 1'b0, 8'h00, 1'b0},
			{KIND_ENC,      8'h4b, 1'b1, 8'h4b, 1'b0},
			{KIND_DEC,      8'h00, 1'b1, 8'h00, 1'b0}
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (plan[i]) begin
			offer(plan[i].kind, plan[i].ch, due, sub);
			if (due) begin
				if (plan[i].typed) begin
					sub.out_char = plan[i].want_char;
					sub.found = plan[i].want_found;
				end
				expected_subs.push_back(sub);
			end
		end

		// random runs: mostly clear, key, finish, text; some noise and broken runs
		while (sent_items < ITEM_TARGET) begin
			gaps_off = (sent_items >= 900 && sent_items < 1150);
			if (!held && sent_items >= 700) begin
				held = 1'b1;
				stall_request = 1'b1;
			end
			if (!drained && sent_items >= 1300) begin
				// stop offering until every result is back
				drained = 1'b1;
				s_tvalid = 1'b0;
				while (expected_subs.size() != 0) @(negedge clk);
			end
			if ($urandom_range(0, 99) < 8) begin
				send_checked(KindW'($urandom_range(0, 7)), CharW'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 99) < 85) send_checked(KIND_CLEAR, pick_char());
				// short keys mostly, sometimes past the square size
				key_len = ($urandom_range(0, 99) < 12) ? $urandom_range(20, 34)
					: $urandom_range(0, 9);
				repeat (key_len) begin
					send_checked(KIND_KEY, ($urandom_range(0, 1) != 0) ? pick_char()
						: CharW'($urandom_range(0, 255)));
				end
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						// broken run: text on a partial square
					end
					3: begin
						send_checked(KIND_FINISH, pick_char());
						send_checked(KIND_FINISH, pick_char());
					end
					default: begin
						send_checked(KIND_FINISH, pick_char());
					end
				endcase
				text_len = $urandom_range(3, 30);
				repeat (text_len) begin
					send_checked(($urandom_range(0, 1) != 0) ? KIND_ENC : KIND_DEC, pick_char());
				end
			end
		end

		s_tvalid = 1'b0;
		gaps_off = 1'b0;
		while (expected_subs.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0 && expected_subs.size() == 0) begin
			$display("[keyed_square_transpose_cipher] OK");
		end else begin
			$display("[keyed_square_transpose_cipher] ERROR");
		end
		$finish;
	end

endmodule
